[rtl/ffud_pkg.sv]
// Shared types, character codes and helpers for the form field decoder.
package ffud_pkg;

  // Character codes
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Body phases
  localparam logic [1:0] PH_MATCH = 2'd0;
  localparam logic [1:0] PH_SKIP  = 2'd1;
  localparam logic [1:0] PH_COPY  = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // Escape progress
  localparam logic [1:0] PCT_NONE  = 2'd0;
  localparam logic [1:0] PCT_SIGN  = 2'd1;
  localparam logic [1:0] PCT_DIGIT = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_KEY_TEXT    = 2'd0;
  localparam logic [1:0] REG_KEY_LENGTH  = 2'd1;
  localparam logic [1:0] REG_VALUE_LIMIT = 2'd2;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned RES_SLOTS  = 3;
  localparam int unsigned FIFO_DEPTH = 4;

  // Per-body state apart from the key position
  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] raw_count;
    logic [1:0] percent_stage;
    logic [7:0] held_char;
    logic       key_found;
  } body_st_t;

  // One result transaction
  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       done_res;
    logic       found;
  } res_t;

  // Hex digit value, zero for anything that is not a hex digit
  function automatic logic [3:0] nibble(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h61 + 8'd10);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h41 + 8'd10);
    return v;
  endfunction

endpackage

[rtl/ffud_in_if.sv]
// Body byte channel: valid/ready handshake with byte and last flag.
interface ffud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       body_last;

  modport source (output valid, output body_byte, output body_last, input ready);
  modport sink   (input valid, input body_byte, input body_last, output ready);
endinterface

[rtl/ffud_out_if.sv]
// Result channel: valid/ready handshake with decoded byte and done status.
interface ffud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       byte_valid;
  logic       done_res;
  logic       found;

  modport source (output valid, output value_byte, output byte_valid, output done_res,
                  output found, input ready);
  modport sink   (input valid, input value_byte, input byte_valid, input done_res,
                  input found, output ready);
endinterface

[rtl/ffud_step.sv]
// Per-byte decision logic: key match, skip, value copy and escape decoding.
module ffud_step #(
  parameter int unsigned MAX_KEY_CHARS = 8,
  parameter int unsigned KPW = $clog2(MAX_KEY_CHARS + 1)
) (
  input  logic [MAX_KEY_CHARS*8-1:0] key_bytes_i,
  input  logic [3:0]                 key_length_i,
  input  logic [7:0]                 value_limit_i,
  input  ffud_pkg::body_st_t         st_i,
  input  logic [KPW-1:0]             key_pos_i,
  input  logic [7:0]                 body_byte_i,
  input  logic                       body_last_i,
  output ffud_pkg::body_st_t         st_o,
  output logic [KPW-1:0]             key_pos_o,
  output ffud_pkg::res_t [ffud_pkg::RES_SLOTS-1:0] res_o,
  output logic [1:0]                 res_cnt_o
);
  import ffud_pkg::*;

  localparam int unsigned KIW = (MAX_KEY_CHARS > 1) ? $clog2(MAX_KEY_CHARS) : 1;

  logic [7:0]     key_chars [MAX_KEY_CHARS];
  logic [KPW-1:0] klen;
  logic [7:0]     kc;

  // Split the key into characters
  always_comb begin
    for (int i = 0; i < MAX_KEY_CHARS; i++) begin
      key_chars[i] = key_bytes_i[i*8 +: 8];
    end
  end

  // Clamp the key length to the stored characters
  assign klen = (key_length_i > 4'(MAX_KEY_CHARS)) ? KPW'(MAX_KEY_CHARS) : KPW'(key_length_i);
  assign kc   = key_chars[key_pos_i[KIW-1:0]];

  always_comb begin
    body_st_t       s;
    logic [KPW-1:0] kp;
    res_t [RES_SLOTS-1:0] r;
    logic [1:0]     n;
    logic           finish;
    logic [7:0]     b;

    s      = st_i;
    kp     = key_pos_i;
    r      = '0;
    n      = 2'd0;
    finish = 1'b0;
    b      = body_byte_i;

    case (s.phase)
      // Compare the field with the key and '='
      PH_MATCH: begin
        if (b == CH_AMP) begin
          kp = '0;
        end else if (kp < klen) begin
          if (b == kc) kp = KPW'(kp + 1'b1);
          else s.phase = PH_SKIP;
        end else if (b == CH_EQ) begin
          s.key_found     = 1'b1;
          s.raw_count     = 8'd0;
          s.percent_stage = PCT_NONE;
          s.phase         = (value_limit_i == 8'd0) ? PH_DONE : PH_COPY;
        end else begin
          s.phase = PH_SKIP;
        end
      end
      // Drop bytes up to the next field
      PH_SKIP: begin
        if (b == CH_AMP) begin
          s.phase = PH_MATCH;
          kp      = '0;
        end
      end
      // Decode one raw value byte
      PH_COPY: begin
        if (b == CH_AMP) begin
          finish = 1'b1;
        end else begin
          s.raw_count = s.raw_count + 8'd1;
          if (s.percent_stage == PCT_SIGN) begin
            s.held_char     = b;
            s.percent_stage = PCT_DIGIT;
          end else if (s.percent_stage == PCT_DIGIT) begin
            r[n] = '{value_byte: {nibble(s.held_char), nibble(b)}, byte_valid: 1'b1,
                     done_res: 1'b0, found: 1'b0};
            n = n + 2'd1;
            s.percent_stage = PCT_NONE;
          end else if (b == CH_PLUS) begin
            r[n] = '{value_byte: CH_SPACE, byte_valid: 1'b1, done_res: 1'b0, found: 1'b0};
            n = n + 2'd1;
          end else if (b == CH_PERCENT) begin
            s.percent_stage = PCT_SIGN;
          end else begin
            r[n] = '{value_byte: b, byte_valid: 1'b1, done_res: 1'b0, found: 1'b0};
            n = n + 2'd1;
          end
          if (s.raw_count >= value_limit_i) finish = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // The body end also closes a value still being copied
    if (body_last_i && s.phase == PH_COPY) finish = 1'b1;

    // Flush a cut-short escape literally and close the value
    if (finish) begin
      if (s.percent_stage != PCT_NONE) begin
        r[n] = '{value_byte: CH_PERCENT, byte_valid: 1'b1, done_res: 1'b0, found: 1'b0};
        n = n + 2'd1;
      end
      if (s.percent_stage == PCT_DIGIT) begin
        r[n] = '{value_byte: (s.held_char == CH_PLUS) ? CH_SPACE : s.held_char,
                 byte_valid: 1'b1, done_res: 1'b0, found: 1'b0};
        n = n + 2'd1;
      end
      s.percent_stage = PCT_NONE;
      s.held_char     = 8'd0;
      s.phase         = PH_DONE;
    end

    // Report the outcome and start afresh for the next body
    if (body_last_i) begin
      r[n] = '{value_byte: 8'd0, byte_valid: 1'b0, done_res: 1'b1, found: s.key_found};
      n = n + 2'd1;
      s  = '{phase: PH_MATCH, raw_count: 8'd0, percent_stage: PCT_NONE, held_char: 8'd0,
             key_found: 1'b0};
      kp = '0;
    end

    st_o      = s;
    key_pos_o = kp;
    res_o     = r;
    res_cnt_o = n;
  end

endmodule

[rtl/form_field_url_decoder.sv]
// Top level of the form field decoder: configuration, body state and result queue.
//
// Usage:
//   Body bytes enter on in_ch (valid/ready), one byte per transaction, with
//   body_last on the final byte. Decoded value bytes and one done transaction
//   per body leave on out_ch (valid/ready), in order.
//   Configuration registers (key text, key length, value limit) are written
//   through cfg_we / cfg_index / cfg_wdata while the block is idle.
// Timing:
//   A byte is decided in the cycle it is accepted; its results are written into a
//   four-entry result queue and leave on out_ch from the queue head, in order.
//   One byte per cycle is taken while the queue can absorb the byte's results
//   (at most three); the queue drains one transaction per cycle while out_ch is
//   ready, so bytes giving several results (escape flush plus done) hold in_ch.
// Reset:
//   rst_n (synchronous, active low) empties the queue, clears the body state
//   and restores key text 0, key length 1 and value limit 32.
// Back-pressure:
//   When out_ch stalls the queue fills; in_ch ready drops once fewer than
//   three free entries would remain, and nothing is lost.
module form_field_url_decoder #(
  parameter int unsigned MAX_KEY_CHARS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ffud_in_if.sink                          in_ch,
  ffud_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [ffud_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ffud_pkg::*;

  localparam int unsigned KPW = $clog2(MAX_KEY_CHARS + 1);
  localparam int unsigned FIW = $clog2(FIFO_DEPTH);
  localparam int unsigned FCW = $clog2(FIFO_DEPTH + 1);

  logic [MAX_KEY_CHARS*8-1:0] key_r;
  logic [3:0]                 key_length_r;
  logic [7:0]                 value_limit_r;

  body_st_t       st_r, st_nxt;
  logic [KPW-1:0] key_pos_r, key_pos_nxt;

  res_t [RES_SLOTS-1:0] step_res;
  logic [1:0]           step_cnt;

  res_t           fifo_r   [FIFO_DEPTH];
  res_t           fifo_nxt [FIFO_DEPTH];
  logic [FCW-1:0] cnt_r, cnt_nxt;

  logic in_take;
  logic out_take;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r         <= '0;
      key_length_r  <= 4'd1;
      value_limit_r <= 8'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_TEXT:    key_r         <= cfg_wdata[MAX_KEY_CHARS*8-1:0];
        REG_KEY_LENGTH:  key_length_r  <= cfg_wdata[3:0];
        REG_VALUE_LIMIT: value_limit_r <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Per-byte decision
  ffud_step #(
    .MAX_KEY_CHARS (MAX_KEY_CHARS),
    .KPW           (KPW)
  ) u_step (
    .key_bytes_i   (key_r),
    .key_length_i  (key_length_r),
    .value_limit_i (value_limit_r),
    .st_i          (st_r),
    .key_pos_i     (key_pos_r),
    .body_byte_i   (in_ch.body_byte),
    .body_last_i   (in_ch.body_last),
    .st_o          (st_nxt),
    .key_pos_o     (key_pos_nxt),
    .res_o         (step_res),
    .res_cnt_o     (step_cnt)
  );

  // Handshakes: accept while the queue keeps room for three results
  assign out_take     = out_ch.valid && out_ch.ready;
  assign in_ch.ready  = (cnt_r <= FCW'(FIFO_DEPTH - RES_SLOTS)) ||
                        ((cnt_r == FCW'(FIFO_DEPTH - RES_SLOTS + 1)) && out_ch.ready);
  assign in_take      = in_ch.valid && in_ch.ready;

  // Advance body state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= '{phase: PH_MATCH, raw_count: 8'd0, percent_stage: PCT_NONE,
                     held_char: 8'd0, key_found: 1'b0};
      key_pos_r <= '0;
    end else if (in_take) begin
      st_r      <= st_nxt;
      key_pos_r <= key_pos_nxt;
    end
  end

  // Result queue: shift out at the head, append behind the remaining entries
  always_comb begin
    logic [FCW-1:0] base;
    base = out_take ? FCW'(cnt_r - 1'b1) : cnt_r;
    for (int j = 0; j < FIFO_DEPTH; j++) begin
      if (out_take && j < FIFO_DEPTH - 1) fifo_nxt[j] = fifo_r[j+1];
      else fifo_nxt[j] = fifo_r[j];
    end
    if (in_take) begin
      for (int i = 0; i < RES_SLOTS; i++) begin
        if (2'(i) < step_cnt) fifo_nxt[FIW'(base + FCW'(i))] = step_res[i];
      end
    end
    cnt_nxt = in_take ? FCW'(base + FCW'(step_cnt)) : base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Hold queue payload
  always_ff @(posedge clk) begin
    for (int j = 0; j < FIFO_DEPTH; j++) begin
      fifo_r[j] <= fifo_nxt[j];
    end
  end

  // Drive the result channel from the queue head
  assign out_ch.valid      = (cnt_r != '0);
  assign out_ch.value_byte = fifo_r[0].value_byte;
  assign out_ch.byte_valid = fifo_r[0].byte_valid;
  assign out_ch.done_res   = fifo_r[0].done_res;
  assign out_ch.found      = fifo_r[0].found;

endmodule
